>>> hdl/mc_european_option_payoff_unit_assert.svh
// Assertion macros for the option payoff unit checker.
// Expects signals clk and rst_n in the scope where a macro is used.
`ifndef MC_EUROPEAN_OPTION_PAYOFF_UNIT_ASSERT_SVH
`define MC_EUROPEAN_OPTION_PAYOFF_UNIT_ASSERT_SVH

// checked outside reset only
`define MCOP_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("mcop assertion failed");

// checked at every edge, reset included
`define MCOP_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("mcop assertion failed");

`endif

>>> hdl/mcop_pkg.sv
// Package for the option payoff unit: sizes, fixed-point constants, shared types.
// No dependencies.
`timescale 1ns / 1ps
package mcop_pkg;
  localparam int COUNT_WIDTH    = 32;
  localparam int EXP_ITERATIONS = 32;
  localparam int ITER_W         = $clog2(EXP_ITERATIONS + 1);
  localparam int QDEPTH         = 4;
  localparam int QPTR_W         = $clog2(QDEPTH);

  localparam logic [63:0]        LN2_Q30  = 64'd744261117;
  localparam logic signed [63:0] EXP_HI   = 64'sd23816355744;
  localparam logic signed [63:0] EXP_LO   = -64'sd24560616861;
  localparam logic [63:0]        EXP_BIAS = 64'd24560616861;
  localparam logic [63:0]        ONE_Q62  = 64'h4000_0000_0000_0000;
  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

  localparam logic [2:0] REG_SPOT   = 3'd0;
  localparam logic [2:0] REG_STRIKE = 3'd1;
  localparam logic [2:0] REG_RATE   = 3'd2;
  localparam logic [2:0] REG_VOL    = 3'd3;
  localparam logic [2:0] REG_TTE    = 3'd4;
  localparam logic [2:0] REG_PUT    = 3'd5;

  typedef struct packed {
    logic signed [31:0] z;
    logic               last;
  } item_t;

  typedef struct packed {
    logic [31:0]        spot;
    logic [31:0]        strike;
    logic signed [31:0] rate;
    logic [31:0]        vol;
    logic [31:0]        tte;
    logic               is_put;
  } cfg_t;

  typedef struct packed {
    logic                   start;
    logic [63:0]            dividend;
    logic [COUNT_WIDTH-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] quotient;
  } div_rsp_t;
endpackage

>>> hdl/mcop_if.sv
// Valid/ready channel interfaces for sample beats in and result beats out.
// Uses no package.
`timescale 1ns / 1ps
interface mcop_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] normal_sample;
  logic               last_sample;
  modport source(output valid, normal_sample, last_sample, input ready);
  modport sink(input valid, normal_sample, last_sample, output ready);
endinterface

interface mcop_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] mean_payoff;
  logic [31:0] samples_used;
  modport source(output valid, mean_payoff, samples_used, input ready);
  modport sink(input valid, mean_payoff, samples_used, output ready);
endinterface

>>> hdl/mcop_front.sv
// Front end: accepts sample beats and holds them in a short queue for the back end.
// Depends on mcop_pkg and mcop_in_if.
`timescale 1ns / 1ps
module mcop_front import mcop_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  mcop_in_if.sink in_ch,
  input  logic  pop,
  output logic  q_valid,
  output item_t q_item
);
  item_t             mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QPTR_W:0]   fill_r;
  logic              push, do_pop;

  assign in_ch.ready = (fill_r != QDEPTH[QPTR_W:0]);
  assign push        = in_ch.valid && in_ch.ready;
  assign q_valid     = (fill_r != '0);
  assign do_pop      = pop && q_valid;
  assign q_item      = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (do_pop) rd_ptr_r <= rd_ptr_r + 1'b1;
      fill_r <= fill_r + {{QPTR_W{1'b0}}, push} - {{QPTR_W{1'b0}}, do_pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= '{z: in_ch.normal_sample, last: in_ch.last_sample};
    end
  end
endmodule

>>> hdl/mcop_div.sv
// Radix-2 restoring divider, one quotient bit per cycle, 64-bit dividend.
// Depends on mcop_pkg.
`timescale 1ns / 1ps
module mcop_div import mcop_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);
  logic                   busy_r, done_r;
  logic [5:0]             cnt_r;
  logic [63:0]            q_r;
  logic [COUNT_WIDTH-1:0] rem_r, d_r;
  logic [COUNT_WIDTH:0]   shl, diff;
  logic                   take;

  assign shl  = {rem_r, q_r[63]};
  assign diff = shl - {1'b0, d_r};
  assign take = (shl >= {1'b0, d_r});
  assign rsp.done     = done_r;
  assign rsp.quotient = q_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= 6'd63;
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      q_r   <= req.dividend;
      d_r   <= req.divisor;
      rem_r <= '0;
    end else if (busy_r) begin
      rem_r <= take ? diff[COUNT_WIDTH-1:0] : shl[COUNT_WIDTH-1:0];
      q_r   <= {q_r[62:0], take};
    end
  end
endmodule

>>> hdl/mcop_back.sv
// Back end: sequencer that prices one path per queued beat over a shared 32x32
// multiplier, square root and exp steps, accumulates, and holds the result register.
// Depends on mcop_pkg, mcop_out_if and mcop_div.
`timescale 1ns / 1ps
module mcop_back import mcop_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  cfg_t  cfg,
  input  logic  q_valid,
  input  item_t q_item,
  output logic  pop,
  mcop_out_if.source out_ch
);
  localparam logic [4:0] S_IDLE   = 5'd0;
  localparam logic [4:0] S_MUL    = 5'd1;
  localparam logic [4:0] S_DRIFT  = 5'd2;
  localparam logic [4:0] S_A      = 5'd3;
  localparam logic [4:0] S_SQRT   = 5'd4;
  localparam logic [4:0] S_VS     = 5'd5;
  localparam logic [4:0] S_B      = 5'd6;
  localparam logic [4:0] S_EXP0   = 5'd7;
  localparam logic [4:0] S_KDIV   = 5'd8;
  localparam logic [4:0] S_TMUL   = 5'd9;
  localparam logic [4:0] S_TDIV   = 5'd10;
  localparam logic [4:0] S_TWAIT  = 5'd11;
  localparam logic [4:0] S_ESCALE = 5'd12;
  localparam logic [4:0] S_PRICE  = 5'd13;
  localparam logic [4:0] S_PAYOFF = 5'd14;
  localparam logic [4:0] S_Y2     = 5'd15;
  localparam logic [4:0] S_DISC   = 5'd16;
  localparam logic [4:0] S_ACC    = 5'd17;
  localparam logic [4:0] S_MEANW  = 5'd18;
  localparam logic [4:0] S_OUT    = 5'd19;

  logic [4:0]   state_r, state_nxt, ret_r, ret_nxt;
  logic [63:0]  mul_a_r, mul_a_nxt, mul_b_r, mul_b_nxt;
  logic [5:0]   sh_r, sh_nxt;
  logic [2:0]   mcnt_r, mcnt_nxt;
  logic [63:0]  pp_r, pp_nxt;
  logic [1:0]   ppsh_r, ppsh_nxt;
  logic [127:0] acc_r, acc_nxt;
  logic         neg_r, neg_nxt;
  logic signed [63:0] a_r, a_nxt, y_r, y_nxt;
  logic signed [31:0] z_r, z_nxt;
  logic         last_r, last_nxt;
  logic [63:0]  sq_rem_r, sq_rem_nxt, sq_res_r, sq_res_nxt;
  logic [4:0]   sq_cnt_r, sq_cnt_nxt;
  logic [6:0]   kq_r, kq_nxt;
  logic [63:0]  krem_r, krem_nxt;
  logic [2:0]   kcnt_r, kcnt_nxt;
  logic [63:0]  term_r, term_nxt, esum_r, esum_nxt, e_r, e_nxt;
  logic [ITER_W-1:0] i_r, i_nxt;
  logic         eret_r, eret_nxt;
  logic [63:0]  payoff_r, payoff_nxt, sum_r, sum_nxt;
  logic [COUNT_WIDTH-1:0] cnt_r, cnt_nxt;
  logic         out_valid_r, out_valid_nxt;
  logic [31:0]  out_mean_r, out_mean_nxt, out_cnt_r, out_cnt_nxt;
  div_req_t     div_req;
  div_rsp_t     div_rsp;

  logic [31:0]  a_h, b_h;
  logic [63:0]  pp_c, hi_sh, mres, sq_bit, sq_res_new;
  logic [127:0] lo_sh;
  logic [64:0]  sq_rb;
  logic signed [63:0] drift, rate_s;
  logic [63:0]  drift_mag, rate_mag, z_mag, mres_sgn, price, strike64, kdv;
  logic signed [7:0] k_c, shamt;
  logic [31:0]  disc;
  logic [64:0]  sum_add;
  logic [63:0]  sum_new;
  logic [COUNT_WIDTH-1:0] cnt_new;
  logic [63:0]  cnt64;

  mcop_div u_div (.clk(clk), .rst_n(rst_n), .req(div_req), .rsp(div_rsp));

  assign a_h   = mcnt_r[1] ? mul_a_r[63:32] : mul_a_r[31:0];
  assign b_h   = mcnt_r[0] ? mul_b_r[63:32] : mul_b_r[31:0];
  assign pp_c  = a_h * b_h;
  assign hi_sh = acc_r[127:64] >> sh_r;
  assign lo_sh = acc_r >> sh_r;
  assign mres  = (hi_sh != '0) ? '1 : lo_sh[63:0];
  assign mres_sgn = neg_r ? (64'd0 - mres) : mres;

  assign sq_bit = 64'd1 << (6'd62 - {sq_cnt_r, 1'b0});
  assign sq_rb  = {1'b0, sq_res_r} + {1'b0, sq_bit};
  assign sq_res_new = ({1'b0, sq_rem_r} >= sq_rb) ? ((sq_res_r >> 1) + sq_bit)
                                                  : (sq_res_r >> 1);

  assign rate_s    = {{32{cfg.rate[31]}}, cfg.rate};
  assign drift     = rate_s - $signed(mres);
  assign drift_mag = drift[63] ? (64'd0 - drift) : drift;
  assign rate_mag  = rate_s[63] ? (64'd0 - rate_s) : rate_s;
  assign z_mag     = z_r[31] ? (64'd0 - {{32{z_r[31]}}, z_r}) : {32'd0, z_r};
  assign price     = mres;
  assign strike64  = {32'd0, cfg.strike};
  assign kdv       = LN2_Q30 << kcnt_r;
  assign k_c       = $signed({1'b0, kq_r}) - 8'sd33;
  assign shamt     = 8'sd30 - k_c;

  assign disc    = (mres[63:32] != '0) ? 32'hFFFF_FFFF : mres[31:0];
  assign sum_add = {1'b0, sum_r} + {33'd0, disc};
  assign sum_new = sum_add[64] ? '1 : sum_add[63:0];
  assign cnt_new = (cnt_r < COUNT_MAX) ? cnt_r + 1'b1 : cnt_r;
  assign cnt64   = {{(64-COUNT_WIDTH){1'b0}}, cnt_r};

  assign out_ch.valid        = out_valid_r;
  assign out_ch.mean_payoff  = out_mean_r;
  assign out_ch.samples_used = out_cnt_r;

  always_comb begin
    state_nxt = state_r;   ret_nxt = ret_r;
    mul_a_nxt = mul_a_r;   mul_b_nxt = mul_b_r;   sh_nxt = sh_r;
    mcnt_nxt = mcnt_r;     pp_nxt = pp_c;         ppsh_nxt = ppsh_r;
    acc_nxt = acc_r;       neg_nxt = neg_r;       a_nxt = a_r;   y_nxt = y_r;
    z_nxt = z_r;           last_nxt = last_r;
    sq_rem_nxt = sq_rem_r; sq_res_nxt = sq_res_r; sq_cnt_nxt = sq_cnt_r;
    kq_nxt = kq_r;         krem_nxt = krem_r;     kcnt_nxt = kcnt_r;
    term_nxt = term_r;     esum_nxt = esum_r;     e_nxt = e_r;
    i_nxt = i_r;           eret_nxt = eret_r;     payoff_nxt = payoff_r;
    sum_nxt = sum_r;       cnt_nxt = cnt_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_mean_nxt = out_mean_r;  out_cnt_nxt = out_cnt_r;
    div_req = '{start: 1'b0, dividend: mres, divisor: {{(COUNT_WIDTH-ITER_W){1'b0}}, i_r}};
    pop = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (q_valid) begin
          pop = 1'b1;
          z_nxt = q_item.z;  last_nxt = q_item.last;
          mul_a_nxt = {32'd0, cfg.vol};  mul_b_nxt = {32'd0, cfg.vol};  sh_nxt = 6'd31;
          acc_nxt = '0;  mcnt_nxt = '0;  ret_nxt = S_DRIFT;  state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        ppsh_nxt = {1'b0, mcnt_r[1]} + {1'b0, mcnt_r[0]};
        if (mcnt_r != '0) acc_nxt = acc_r + ({64'd0, pp_r} << {ppsh_r, 5'd0});
        if (mcnt_r == 3'd4) state_nxt = ret_r;
        else mcnt_nxt = mcnt_r + 1'b1;
      end
      S_DRIFT: begin
        mul_a_nxt = drift_mag;  mul_b_nxt = {32'd0, cfg.tte};  sh_nxt = 6'd24;
        neg_nxt = drift[63];
        acc_nxt = '0;  mcnt_nxt = '0;  ret_nxt = S_A;  state_nxt = S_MUL;
      end
      S_A: begin
        a_nxt = mres_sgn;
        sq_rem_nxt = {cfg.tte, 32'd0};  sq_res_nxt = '0;  sq_cnt_nxt = '0;
        state_nxt = S_SQRT;
      end
      S_SQRT: begin
        if ({1'b0, sq_rem_r} >= sq_rb) sq_rem_nxt = sq_rem_r - sq_rb[63:0];
        sq_res_nxt = sq_res_new;
        sq_cnt_nxt = sq_cnt_r + 1'b1;
        if (sq_cnt_r == 5'd31) begin
          mul_a_nxt = {32'd0, cfg.vol};  mul_b_nxt = sq_res_new;  sh_nxt = 6'd28;
          acc_nxt = '0;  mcnt_nxt = '0;  ret_nxt = S_VS;  state_nxt = S_MUL;
        end
      end
      S_VS: begin
        mul_a_nxt = z_mag;  mul_b_nxt = mres;  sh_nxt = 6'd28;  neg_nxt = z_r[31];
        acc_nxt = '0;  mcnt_nxt = '0;  ret_nxt = S_B;  state_nxt = S_MUL;
      end
      S_B: begin
        y_nxt = a_r + $signed(mres_sgn);
        eret_nxt = 1'b0;  state_nxt = S_EXP0;
      end
      S_EXP0: begin
        if (y_r >= EXP_HI) begin
          e_nxt = '1;  state_nxt = eret_r ? S_DISC : S_PRICE;
        end else if (y_r < EXP_LO) begin
          e_nxt = '0;  state_nxt = eret_r ? S_DISC : S_PRICE;
        end else begin
          krem_nxt = $unsigned(y_r) + EXP_BIAS;
          kq_nxt = '0;  kcnt_nxt = 3'd6;  state_nxt = S_KDIV;
        end
      end
      S_KDIV: begin
        if (krem_r >= kdv) begin
          krem_nxt = krem_r - kdv;
          kq_nxt[kcnt_r] = 1'b1;
        end
        if (kcnt_r == '0) begin
          term_nxt = ONE_Q62;  esum_nxt = ONE_Q62;
          i_nxt = {{(ITER_W-1){1'b0}}, 1'b1};  state_nxt = S_TMUL;
        end else begin
          kcnt_nxt = kcnt_r - 1'b1;
        end
      end
      S_TMUL: begin
        mul_a_nxt = term_r;  mul_b_nxt = krem_r;  sh_nxt = 6'd30;
        acc_nxt = '0;  mcnt_nxt = '0;  ret_nxt = S_TDIV;  state_nxt = S_MUL;
      end
      S_TDIV: begin
        div_req.start = 1'b1;
        state_nxt = S_TWAIT;
      end
      S_TWAIT: begin
        if (div_rsp.done) begin
          term_nxt = div_rsp.quotient;
          esum_nxt = esum_r + div_rsp.quotient;
          if (i_r == ITER_W'(EXP_ITERATIONS)) begin
            state_nxt = S_ESCALE;
          end else begin
            i_nxt = i_r + 1'b1;
            state_nxt = S_TMUL;
          end
        end
      end
      S_ESCALE: begin
        if (k_c > 8'sd30) e_nxt = esum_r[63] ? '1 : (esum_r << 1);
        else e_nxt = esum_r >> shamt[5:0];
        state_nxt = eret_r ? S_DISC : S_PRICE;
      end
      S_PRICE: begin
        mul_a_nxt = e_r;  mul_b_nxt = {32'd0, cfg.spot};  sh_nxt = 6'd32;
        acc_nxt = '0;  mcnt_nxt = '0;  ret_nxt = S_PAYOFF;  state_nxt = S_MUL;
      end
      S_PAYOFF: begin
        if (cfg.is_put) payoff_nxt = (strike64 > price) ? strike64 - price : '0;
        else payoff_nxt = (price > strike64) ? price - strike64 : '0;
        mul_a_nxt = rate_mag;  mul_b_nxt = {32'd0, cfg.tte};  sh_nxt = 6'd24;
        neg_nxt = cfg.rate[31];
        acc_nxt = '0;  mcnt_nxt = '0;  ret_nxt = S_Y2;  state_nxt = S_MUL;
      end
      S_Y2: begin
        y_nxt = neg_r ? $signed(mres) : $signed(64'd0 - mres);
        eret_nxt = 1'b1;  state_nxt = S_EXP0;
      end
      S_DISC: begin
        mul_a_nxt = payoff_r;  mul_b_nxt = e_r;  sh_nxt = 6'd32;
        acc_nxt = '0;  mcnt_nxt = '0;  ret_nxt = S_ACC;  state_nxt = S_MUL;
      end
      S_ACC: begin
        sum_nxt = sum_new;
        cnt_nxt = cnt_new;
        if (last_r) begin
          div_req = '{start: 1'b1, dividend: sum_new, divisor: cnt_new};
          state_nxt = S_MEANW;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_MEANW: begin
        if (div_rsp.done) state_nxt = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          out_mean_nxt = (div_rsp.quotient[63:32] != '0) ? 32'hFFFF_FFFF
                                                         : div_rsp.quotient[31:0];
          out_cnt_nxt = (cnt64 > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : cnt64[31:0];
          sum_nxt = '0;
          cnt_nxt = '0;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      sum_r       <= '0;
      cnt_r       <= '0;
      mcnt_r      <= '0;
      sq_cnt_r    <= '0;
      kcnt_r      <= '0;
      i_r         <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      sum_r       <= sum_nxt;
      cnt_r       <= cnt_nxt;
      mcnt_r      <= mcnt_nxt;
      sq_cnt_r    <= sq_cnt_nxt;
      kcnt_r      <= kcnt_nxt;
      i_r         <= i_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ret_r <= ret_nxt;      mul_a_r <= mul_a_nxt;   mul_b_r <= mul_b_nxt;
    sh_r <= sh_nxt;        pp_r <= pp_nxt;         ppsh_r <= ppsh_nxt;
    acc_r <= acc_nxt;      neg_r <= neg_nxt;       a_r <= a_nxt;
    y_r <= y_nxt;          z_r <= z_nxt;           last_r <= last_nxt;
    sq_rem_r <= sq_rem_nxt; sq_res_r <= sq_res_nxt;
    kq_r <= kq_nxt;        krem_r <= krem_nxt;
    term_r <= term_nxt;    esum_r <= esum_nxt;     e_r <= e_nxt;
    eret_r <= eret_nxt;    payoff_r <= payoff_nxt;
    out_mean_r <= out_mean_nxt;
    out_cnt_r <= out_cnt_nxt;
  end
endmodule

>>> hdl/mc_european_option_payoff_unit.sv
// Monte Carlo European option payoff unit. One sample beat at a time: the time per
// beat is mostly set by the two exp Taylor loops of EXP_ITERATIONS (32) terms, each
// term a multiply on the shared multiplier followed by a divide on the shared divider.
// A beat marked last adds the mean divide; a 4-deep queue buffers input.
// Synchronous active-low reset clears the registers to their defaults, sum and count.
`timescale 1ns / 1ps
module mc_european_option_payoff_unit import mcop_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  mcop_in_if.sink     in_ch,
  mcop_out_if.source  out_ch,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  cfg_t  cfg_r;
  logic  q_valid, pop;
  item_t q_item;
  logic  wr_en;

  assign cfg_pready = 1'b1;
  assign wr_en = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.spot   <= 32'd6553600;
      cfg_r.strike <= 32'd6553600;
      cfg_r.rate   <= 32'sd53687091;
      cfg_r.vol    <= 32'd214748365;
      cfg_r.tte    <= 32'd16777216;
      cfg_r.is_put <= 1'b0;
    end else if (wr_en) begin
      unique case (cfg_paddr[4:2])
        REG_SPOT:   cfg_r.spot   <= cfg_pwdata;
        REG_STRIKE: cfg_r.strike <= cfg_pwdata;
        REG_RATE:   cfg_r.rate   <= cfg_pwdata;
        REG_VOL:    cfg_r.vol    <= cfg_pwdata;
        REG_TTE:    cfg_r.tte    <= cfg_pwdata;
        REG_PUT:    cfg_r.is_put <= cfg_pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr[4:2])
      REG_SPOT:   cfg_prdata = cfg_r.spot;
      REG_STRIKE: cfg_prdata = cfg_r.strike;
      REG_RATE:   cfg_prdata = cfg_r.rate;
      REG_VOL:    cfg_prdata = cfg_r.vol;
      REG_TTE:    cfg_prdata = cfg_r.tte;
      REG_PUT:    cfg_prdata = {31'd0, cfg_r.is_put};
      default:    cfg_prdata = '0;
    endcase
  end

  mcop_front u_front (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch),
    .pop(pop), .q_valid(q_valid), .q_item(q_item)
  );

  mcop_back u_back (
    .clk(clk), .rst_n(rst_n), .cfg(cfg_r),
    .q_valid(q_valid), .q_item(q_item), .pop(pop), .out_ch(out_ch)
  );
endmodule

>>> hdl/mcop_checker.sv
// Port-level checker for the option payoff unit, bound to the top level.
// Depends on mc_european_option_payoff_unit_assert.svh.
`timescale 1ns / 1ps
`include "mc_european_option_payoff_unit_assert.svh"
module mcop_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] mean_payoff,
  input logic [31:0] samples_used,
  input logic        cfg_pready
);
  `MCOP_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid)
  `MCOP_ASSERT(a_out_stable, out_valid && !out_ready |=> $stable(mean_payoff) && $stable(samples_used))
  `MCOP_ASSERT(a_count_nonzero, out_valid |-> samples_used != 32'd0)
  `MCOP_ASSERT_ALWAYS(a_pready_high, cfg_pready)
endmodule

bind mc_european_option_payoff_unit mcop_checker u_mcop_checker (
  .clk(clk), .rst_n(rst_n),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .mean_payoff(out_ch.mean_payoff), .samples_used(out_ch.samples_used),
  .cfg_pready(cfg_pready)
);

>>> dv/tb_mc_european_option_payoff_unit.sv
// Testbench for mc_european_option_payoff_unit: directed table, then random batches.
// Checked against a fixed-point payoff predictor in this file or typed table values.
// Depends on mcop_pkg and the channel interfaces in mcop_if.sv.
`timescale 1ns / 1ps
module tb_mc_european_option_payoff_unit;
  import mcop_pkg::*;

  localparam int WATCHDOG = 200000;
  localparam int DRAIN    = 5000;
  localparam int PHASES   = 8;
  localparam int PHASE_N  = 60;

  typedef struct packed {
    logic [31:0] mean;
    logic [31:0] cnt;
  } res_t;

  typedef struct {
    bit   typed;
    res_t val;
  } hint_t;

  typedef struct {
    int                 cfg;
    logic signed [31:0] z;
    bit                 last;
    bit                 typed;
    res_t               val;
  } row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  always #10 clk = ~clk;

  mcop_in_if  in_ch();
  mcop_out_if out_ch();

  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [4:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  mc_european_option_payoff_unit i_dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  cfg_t        cur_cfg;
  logic [63:0] payoff_acc;
  logic [63:0] sample_cnt;
  res_t        mean_due[$];
  hint_t       typed_due[$];
  int          n_taken = 0;
  int          n_bad = 0;
  int          quiet = 0;
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  bit          got_has;
  res_t        got_r;
  hint_t       h;
  res_t        want;

  function automatic logic [63:0] fx_mul(logic [63:0] a, logic [63:0] b, int s);
    logic [127:0] p;
    p = {64'b0, a} * {64'b0, b};
    p = p >> s;
    return (p[127:64] != 0) ? '1 : p[63:0];
  endfunction

  function automatic longint fx_muls(longint a, logic [63:0] b, int s);
    logic [63:0] mag;
    logic [63:0] p;
    mag = (a < 0) ? -a : a;
    p = fx_mul(mag, b, s);
    return (a < 0) ? -longint'(p) : longint'(p);
  endfunction

  function automatic logic [63:0] isqrt64(logic [63:0] n);
    logic [63:0] rem, res, bv;
    rem = n;
    res = 0;
    bv = 64'd1 << 62;
    while (bv > n) bv = bv >> 2;
    while (bv != 0) begin
      if (rem >= res + bv) begin
        rem = rem - (res + bv);
        res = (res >> 1) + bv;
      end else begin
        res = res >> 1;
      end
      bv = bv >> 2;
    end
    return res;
  endfunction

  function automatic logic [63:0] exp_fx(longint y);
    longint      ln2, k, f;
    logic [63:0] term, sum;
    int          sh;
    ln2 = longint'(LN2_Q30);
    k = y / ln2;
    if (y % ln2 < 0) k = k - 1;
    f = y - k * ln2;
    if (k >= 32) return '1;
    if (k < -33) return '0;
    term = ONE_Q62;
    sum = ONE_Q62;
    for (int i = 1; i <= EXP_ITERATIONS; i++) begin
      term = fx_mul(term, f, 30) / i;
      sum = sum + term;
    end
    if (k > 30) begin
      sh = int'(k - 30);
      if ((sum >> (64 - sh)) != 0) return '1;
      return sum << sh;
    end
    return sum >> (30 - k);
  endfunction

  task automatic accumulate_sample(input logic signed [31:0] z, input logic last,
                                   output bit has, output res_t r);
    logic [63:0] tt, vol, st, vs, price, payoff, disc, mean;
    longint      rate, drift, a, b;
    tt = {32'b0, cur_cfg.tte};
    vol = {32'b0, cur_cfg.vol};
    rate = longint'($signed(cur_cfg.rate));
    drift = rate - longint'(fx_mul(vol, vol, 31));
    a = fx_muls(drift, tt, 24);
    st = isqrt64(tt << 32);
    vs = fx_mul(vol, st, 28);
    b = fx_muls(longint'(z), vs, 28);
    price = fx_mul(exp_fx(a + b), {32'b0, cur_cfg.spot}, 32);
    if (cur_cfg.is_put)
      payoff = ({32'b0, cur_cfg.strike} > price) ? {32'b0, cur_cfg.strike} - price : 0;
    else
      payoff = (price > {32'b0, cur_cfg.strike}) ? price - {32'b0, cur_cfg.strike} : 0;
    disc = fx_mul(payoff, exp_fx(-fx_muls(rate, tt, 24)), 32);
    if (disc > 64'hFFFF_FFFF) disc = 64'hFFFF_FFFF;
    payoff_acc = (~payoff_acc < disc) ? '1 : payoff_acc + disc;
    if (sample_cnt < {32'b0, COUNT_MAX}) sample_cnt = sample_cnt + 1;
    has = last;
    r = '0;
    if (last) begin
      mean = payoff_acc / sample_cnt;
      r.mean = (mean > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : mean[31:0];
      r.cnt = (sample_cnt > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : sample_cnt[31:0];
      payoff_acc = 0;
      sample_cnt = 0;
    end
  endtask

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] exp_v);
    $display("%0t mismatch %s: got %h, want %h", $realtime, what, got, exp_v);
    n_bad++;
  endtask

  always @(posedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready) begin
      accumulate_sample(in_ch.normal_sample, in_ch.last_sample, got_has, got_r);
      h = typed_due.pop_front();
      if (got_has) mean_due.push_back(h.typed ? h.val : got_r);
      n_taken <= n_taken + 1;
    end
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (mean_due.size() == 0) begin
        report("unexpected beat", out_ch.mean_payoff, '0);
      end else begin
        want = mean_due.pop_front();
        if (out_ch.mean_payoff !== want.mean) report("mean_payoff", out_ch.mean_payoff, want.mean);
        if (out_ch.samples_used !== want.cnt) report("samples_used", out_ch.samples_used, want.cnt);
      end
    end
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet > WATCHDOG) begin
      $display("[mc_european_option_payoff_unit] ERROR");
      $finish;
    end
  end

  always @(negedge clk) out_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);

  task automatic send_beat(input logic signed [31:0] z, input logic last, input hint_t hv);
    int seen;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
    typed_due.push_back(hv);
    seen = n_taken;
    in_ch.valid = 1'b1;
    in_ch.normal_sample = z;
    in_ch.last_sample = last;
    do @(negedge clk); while (n_taken == seen);
  endtask

  task automatic wait_idle();
    in_ch.valid = 1'b0;
    while (mean_due.size() != 0) @(negedge clk);
    repeat (DRAIN) @(negedge clk);
  endtask

  task automatic reg_write(input logic [2:0] idx, input logic [31:0] val);
    cfg_psel = 1'b1;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b1;
    cfg_paddr = {idx, 2'b00};
    cfg_pwdata = val;
    @(negedge clk);
    cfg_penable = 1'b1;
    @(negedge clk);
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
  endtask

  task automatic apply_cfg(input cfg_t c);
    wait_idle();
    reg_write(REG_SPOT, c.spot);
    reg_write(REG_STRIKE, c.strike);
    reg_write(REG_RATE, c.rate);
    reg_write(REG_VOL, c.vol);
    reg_write(REG_TTE, c.tte);
    reg_write(REG_PUT, {31'b0, c.is_put});
    cur_cfg = c;
  endtask

  cfg_t  setups[6];
  row_t  rows[$];
  hint_t none_h;
  hint_t th;
  cfg_t  rc;
  int    cur_setup;
  logic signed [31:0] z;

  initial begin
    in_ch.valid = 1'b0;
    in_ch.normal_sample = '0;
    in_ch.last_sample = 1'b0;
    out_ch.ready = 1'b0;
    cur_cfg = '{spot: 32'd6553600, strike: 32'd6553600, rate: 32'sd53687091,
                vol: 32'd214748365, tte: 32'd16777216, is_put: 1'b0};
    payoff_acc = 0;
    sample_cnt = 0;
    none_h = '{typed: 1'b0, val: '0};
    setups[0] = cur_cfg;
    setups[1] = '{spot: 0, strike: 32'd6553600, rate: 32'sd53687091,
                  vol: 32'd214748365, tte: 32'd16777216, is_put: 1'b0};
    setups[2] = '{spot: 0, strike: 32'hFFFF_FFFF, rate: 0,
                  vol: 32'd214748365, tte: 32'd16777216, is_put: 1'b1};
    setups[3] = '{spot: 32'd6553600, strike: 0, rate: 32'h8000_0000,
                  vol: 0, tte: 32'hFFFF_FFFF, is_put: 1'b0};
    setups[4] = '{spot: 32'hFFFF_FFFF, strike: 0, rate: 32'h7FFF_FFFF,
                  vol: 32'hFFFF_FFFF, tte: 32'hFFFF_FFFF, is_put: 1'b0};
    setups[5] = '{spot: 32'd6553600, strike: 32'hFFFF_FFFF, rate: 0,
                  vol: 0, tte: 0, is_put: 1'b1};
    rows = '{
      '{0, 32'sd0,          1, 0, '0},
      '{0, 32'sh7FFF_FFFF,  0, 0, '0},
      '{0, 32'sh8000_0000,  1, 0, '0},
      '{0, 32'sh1000_0000,  0, 0, '0},
      '{0, -32'sh1000_0000, 0, 0, '0},
      '{0, 32'sh0800_0000,  1, 0, '0},
      '{1, 32'sh7FFF_FFFF,  1, 1, '{32'd0, 32'd1}},
      '{1, 32'sh8000_0000,  0, 0, '0},
      '{1, 32'sd0,          1, 1, '{32'd0, 32'd2}},
      '{2, 32'sd1,          1, 1, '{32'hFFFF_FFFF, 32'd1}},
      '{2, 32'sh8000_0000,  0, 0, '0},
      '{2, 32'sh7FFF_FFFF,  1, 1, '{32'hFFFF_FFFF, 32'd2}},
      '{3, 32'sd0,          1, 0, '0},
      '{3, 32'sh7FFF_FFFF,  1, 0, '0},
      '{4, 32'sh7FFF_FFFF,  1, 0, '0},
      '{4, 32'sh8000_0000,  1, 0, '0},
      '{5, 32'sd0,          1, 1, '{32'hFF9B_FFFF, 32'd1}},
      '{5, 32'sh8000_0000,  0, 0, '0},
      '{5, 32'sh7FFF_FFFF,  1, 0, '0}
    };
    repeat (8) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    send_idle_pct = 18;
    recv_idle_pct = 45;
    cur_setup = 0;
    foreach (rows[i]) begin
      if (rows[i].cfg != cur_setup) begin
        cur_setup = rows[i].cfg;
        apply_cfg(setups[cur_setup]);
      end
      th = '{typed: rows[i].typed, val: rows[i].val};
      send_beat(rows[i].z, rows[i].last, th);
    end

    for (int p = 0; p < PHASES; p++) begin
      send_idle_pct = (p < 3) ? 18 : (p < 6) ? 45 : 0;
      recv_idle_pct = (p < 3) ? 45 : (p < 6) ? 18 : 0;
      if (p % 4 == 3) begin
        rc = '{spot: $urandom, strike: $urandom, rate: $urandom, vol: $urandom,
               tte: $urandom, is_put: $urandom_range(0, 1)};
      end else begin
        rc.spot = $urandom_range(32'h0010_0000, 32'h0100_0000);
        rc.strike = rc.spot + $urandom_range(0, 32'h0040_0000) - 32'h0020_0000;
        rc.rate = $signed($urandom_range(0, 32'h1000_0000)) - 32'sh0400_0000;
        rc.vol = $urandom_range(0, 32'h4000_0000);
        rc.tte = $urandom_range(0, 32'h0800_0000);
        rc.is_put = $urandom_range(0, 1);
      end
      apply_cfg(rc);
      for (int n = 0; n < PHASE_N; n++) begin
        z = $signed($urandom) >>> $urandom_range(0, 4);
        send_beat(z, (n == PHASE_N - 1) || ($urandom_range(0, 7) == 0), none_h);
      end
    end

    wait_idle();
    if (n_bad == 0) begin
      $display("[mc_european_option_payoff_unit] OK");
    end else begin
      $display("[mc_european_option_payoff_unit] ERROR");
    end
    $finish;
  end
endmodule

>>> files.f
+incdir+hdl
hdl/mcop_pkg.sv
hdl/mcop_if.sv
hdl/mcop_front.sv
hdl/mcop_div.sv
hdl/mcop_back.sv
hdl/mc_european_option_payoff_unit.sv
hdl/mcop_checker.sv
dv/tb_mc_european_option_payoff_unit.sv
